// File: sv/nrh_pkg.sv
// ----------------------------------------------------------------------------
// nrh_pkg
// Shared constants, widths and controller/datapath command types.
// ----------------------------------------------------------------------------
package nrh_pkg;

    localparam int MAX_SAMPLES  = 4096;
    localparam int MAX_BINS     = 64;
    localparam int SAMPLE_WIDTH = 16;

    localparam int ADDR_W  = $clog2(MAX_SAMPLES);
    localparam int HELD_W  = $clog2(MAX_SAMPLES + 1);
    localparam int BIN_W   = $clog2(MAX_BINS);
    localparam int NB_W    = $clog2(MAX_BINS + 1);
    localparam int SPAN_W  = SAMPLE_WIDTH + 1;
    localparam int PROD_W  = SPAN_W + NB_W;
    localparam int QUO_W   = PROD_W;
    localparam int NORM_W  = 17;
    localparam int DIVN_W  = HELD_W + 16;
    localparam int CFG_W   = 7;
    localparam int CFG_RESET = 64;

    typedef struct packed {
        logic load;        // store one sample
        logic clear;       // reset run state
        logic bin_rd;      // issue memory read
        logic count_inc;   // bump the count of the selected bin
        logic norm_start;  // start normalize division
        logic peak_step;   // compare one bin for peak
    } nrh_cmd_t;

    typedef struct packed {
        logic div_done;
    } nrh_sts_t;

endpackage

// File: sv/nrh_div.sv
// ----------------------------------------------------------------------------
// nrh_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module nrh_div (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         start,
    input  logic [nrh_pkg::DIVN_W-1:0]   dividend,
    input  logic [nrh_pkg::DIVN_W-1:0]   divisor,
    output logic                         done,
    output logic [nrh_pkg::DIVN_W-1:0]   quotient
);
    localparam int W  = nrh_pkg::DIVN_W;
    localparam int CW = $clog2(W + 1);

    logic [W-1:0]  q_reg, q_next;
    logic [W:0]    r_reg, r_next;
    logic [W-1:0]  d_reg;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          busy_reg, busy_next;
    logic [W:0]    trial;

    always_comb begin
        q_next    = q_reg;
        r_next    = r_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        trial     = {r_reg[W-1:0], q_reg[W-1]};
        if (start) begin
            q_next    = dividend;
            r_next    = '0;
            cnt_next  = CW'(W);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (trial >= {1'b0, d_reg}) begin
                r_next = trial - {1'b0, d_reg};
                q_next = {q_reg[W-2:0], 1'b1};
            end else begin
                r_next = trial;
                q_next = {q_reg[W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1)) busy_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        q_reg <= q_next;
        r_reg <= r_next;
        if (start) d_reg <= divisor;
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    assign done     = busy_reg && (cnt_reg == CW'(1));
    assign quotient = q_next;
endmodule

// File: sv/nrh_ctrl.sv
// ----------------------------------------------------------------------------
// nrh_ctrl
// Run sequencer: load, bin pass, peak search, normalize and emit.
// ----------------------------------------------------------------------------
module nrh_ctrl (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic                          s_last,
    input  logic [nrh_pkg::HELD_W-1:0]    held,
    input  logic [nrh_pkg::BIN_W:0]       nb,
    input  logic                          zero_span,
    input  nrh_pkg::nrh_sts_t             sts,
    output nrh_pkg::nrh_cmd_t             cmd,
    output logic [nrh_pkg::ADDR_W-1:0]    rd_idx,
    output logic [nrh_pkg::BIN_W-1:0]     bin_idx,
    output logic                          out_load,
    input  logic                          out_free
);
    localparam logic [2:0] S_LOAD = 3'd0;
    localparam logic [2:0] S_RD   = 3'd1;
    localparam logic [2:0] S_DIV  = 3'd2;
    localparam logic [2:0] S_PEAK = 3'd3;
    localparam logic [2:0] S_NRM  = 3'd4;
    localparam logic [2:0] S_NWT  = 3'd5;
    localparam logic [2:0] S_EMIT = 3'd6;
    localparam logic [2:0] S_NRD  = 3'd7;

    logic [2:0]                    st_reg, st_next;
    logic [nrh_pkg::HELD_W-1:0]    i_reg, i_next;
    logic [nrh_pkg::BIN_W-1:0]     b_reg, b_next;
    logic                          acc;
    logic                          last_b;

    assign acc     = s_tvalid && s_tready;
    assign rd_idx  = i_reg[nrh_pkg::ADDR_W-1:0];
    assign bin_idx = b_reg;
    assign last_b  = ({1'b0, b_reg} == nb - 1'b1);

    always_comb begin
        st_next  = st_reg;
        i_next   = i_reg;
        b_next   = b_reg;
        cmd      = '0;
        s_tready = 1'b0;
        out_load = 1'b0;
        unique case (st_reg)
            S_LOAD: begin
                s_tready = 1'b1;
                if (acc) begin
                    cmd.load = 1'b1;
                    if (s_last) begin
                        st_next = S_RD;
                        i_next  = '0;
                    end
                end
            end
            S_RD: begin
                if (i_reg == held) begin
                    st_next = S_PEAK;
                    b_next  = '0;
                end else begin
                    cmd.bin_rd = 1'b1;
                    st_next    = S_DIV;
                end
            end
            S_DIV: begin
                if (zero_span) begin
                    cmd.count_inc = 1'b1;
                    i_next  = i_reg + 1'b1;
                    st_next = S_RD;
                end else if (sts.div_done) begin
                    cmd.count_inc = 1'b1;
                    i_next  = i_reg + 1'b1;
                    st_next = S_RD;
                end
            end
            S_PEAK: begin
                cmd.peak_step = 1'b1;
                b_next = b_reg + 1'b1;
                if (last_b) begin
                    b_next  = '0;
                    st_next = S_NRD;
                end
            end
            S_NRD: begin
                st_next = S_NRM;
            end
            S_NRM: begin
                cmd.norm_start = 1'b1;
                st_next = S_NWT;
            end
            S_NWT: begin
                if (sts.div_done) st_next = S_EMIT;
            end
            S_EMIT: begin
                if (out_free) begin
                    out_load = 1'b1;
                    if (last_b) begin
                        cmd.clear = 1'b1;
                        b_next  = '0;
                        st_next = S_LOAD;
                    end else begin
                        b_next  = b_reg + 1'b1;
                        st_next = S_NRD;
                    end
                end
            end
            default: st_next = S_LOAD;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg   <= S_LOAD;
            i_reg    <= '0;
            b_reg    <= '0;
        end else begin
            st_reg   <= st_next;
            i_reg    <= i_next;
            b_reg    <= b_next;
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> st_reg == S_LOAD)
        else $error("ready outside load");
    assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |-> out_free)
        else $error("emit into full output");
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.bin_rd |=> st_reg == S_DIV)
        else $error("read without divide");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (st_reg == S_PEAK || st_reg == S_EMIT) |-> {1'b0, b_reg} < nb)
        else $error("bin index beyond range");
endmodule

// File: sv/nrh_dpath.sv
// ----------------------------------------------------------------------------
// nrh_dpath
// Sample memory, range tracking, bin counters, divider and output register.
// ----------------------------------------------------------------------------
module nrh_dpath (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic signed [nrh_pkg::SAMPLE_WIDTH-1:0] s_sample,
    input  logic [nrh_pkg::CFG_W-1:0]             cfg_wdata,
    input  logic                                  cfg_wen,
    input  nrh_pkg::nrh_cmd_t                     cmd,
    input  logic [nrh_pkg::ADDR_W-1:0]            rd_idx,
    input  logic [nrh_pkg::BIN_W-1:0]             bin_idx,
    input  logic                                  out_load,
    input  logic                                  m_tready,
    output logic                                  m_tvalid,
    output logic [63:0]                           m_tdata,
    output logic                                  m_tlast,
    output logic                                  out_free,
    output logic [nrh_pkg::HELD_W-1:0]            held,
    output logic [nrh_pkg::BIN_W:0]               nb,
    output logic                                  zero_span,
    output nrh_pkg::nrh_sts_t                     sts
);
    localparam int SW  = nrh_pkg::SAMPLE_WIDTH;
    localparam int DW  = nrh_pkg::DIVN_W;
    localparam int CNW = nrh_pkg::HELD_W;
    localparam logic signed [SW-1:0] SMAX = {1'b0, {(SW-1){1'b1}}};
    localparam logic signed [SW-1:0] SMIN = {1'b1, {(SW-1){1'b0}}};

    logic signed [SW-1:0] mem [nrh_pkg::MAX_SAMPLES];
    logic signed [SW-1:0] rdat_reg;
    logic [nrh_pkg::CFG_W-1:0] cfg_reg;
    logic signed [SW-1:0] min_reg, max_reg;
    logic [CNW-1:0]       held_reg;
    logic                 drop_reg;
    logic [CNW-1:0]       cnt_mem [nrh_pkg::MAX_BINS];
    logic [nrh_pkg::MAX_BINS-1:0] cnt_vld_reg;
    logic [CNW-1:0]       cnt_rd_reg;
    logic                 cnt_rvld_reg;
    logic [CNW-1:0]       cnt_rdata;
    logic [nrh_pkg::BIN_W-1:0] cnt_raddr;
    logic [nrh_pkg::BIN_W-1:0] inc_addr_reg;
    logic                 inc_pend_reg;
    logic                 peak_d_reg;
    logic [CNW-1:0]       peak_reg;
    logic                 rd_d_reg;
    logic [nrh_pkg::SPAN_W-1:0] span;
    logic [nrh_pkg::SPAN_W-1:0] diff;
    logic [DW-1:0]        prod_reg;
    logic                 start_d_reg;
    logic                 div_start;
    logic [DW-1:0]        div_n, div_d, quo;
    logic                 div_done;
    logic [nrh_pkg::BIN_W-1:0] bin_sel;
    logic [DW-1:0]        nbm1;

    always_comb begin
        if (cfg_reg < nrh_pkg::CFG_W'(2)) nb = (nrh_pkg::BIN_W+1)'(2);
        else if (cfg_reg > nrh_pkg::CFG_W'(nrh_pkg::MAX_BINS))
            nb = (nrh_pkg::BIN_W+1)'(nrh_pkg::MAX_BINS);
        else nb = cfg_reg[nrh_pkg::BIN_W:0];
    end

    assign held      = held_reg;
    assign span      = nrh_pkg::SPAN_W'(signed'({max_reg[SW-1], max_reg})
                       - signed'({min_reg[SW-1], min_reg}));
    assign zero_span = (max_reg <= min_reg);
    assign diff      = nrh_pkg::SPAN_W'(signed'({rdat_reg[SW-1], rdat_reg})
                       - signed'({min_reg[SW-1], min_reg}));
    assign nbm1      = DW'(nb - 1'b1);

    // sample memory
    always_ff @(posedge aclk) begin
        if (cmd.load && held_reg < CNW'(nrh_pkg::MAX_SAMPLES))
            mem[held_reg[nrh_pkg::ADDR_W-1:0]] <= s_sample;
        if (cmd.bin_rd) rdat_reg <= mem[rd_idx];
    end

    // product (nb-1)*diff registered from the read data, then divide
    always_ff @(posedge aclk) begin
        prod_reg <= DW'(nbm1 * DW'(diff));
        if (!aresetn) begin
            rd_d_reg    <= 1'b0;
            start_d_reg <= 1'b0;
        end else begin
            rd_d_reg    <= cmd.bin_rd && !zero_span;
            start_d_reg <= rd_d_reg;
        end
    end

    // peak zero cannot occur after a run; a zero peak forces the normalized count to zero anyway
    assign div_start = start_d_reg || cmd.norm_start;
    assign div_n = cmd.norm_start ? {cnt_rdata, 16'd0} : prod_reg;
    assign div_d = cmd.norm_start ? DW'(peak_reg) : DW'(span);
    assign sts.div_done = div_done && !div_start;

    nrh_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_n),
        .divisor  (div_d),
        .done     (div_done),
        .quotient (quo)
    );

    assign bin_sel = zero_span ? '0 :
                     (quo > nbm1) ? nbm1[nrh_pkg::BIN_W-1:0] : quo[nrh_pkg::BIN_W-1:0];

    // bin counters: registered read, write back the increment in the next cycle
    assign cnt_raddr = cmd.count_inc ? bin_sel : bin_idx;
    assign cnt_rdata = cnt_rvld_reg ? cnt_rd_reg : '0;

    always_ff @(posedge aclk) begin
        cnt_rd_reg <= cnt_mem[cnt_raddr];
        if (inc_pend_reg) cnt_mem[inc_addr_reg] <= cnt_rdata + 1'b1;
    end

    always_ff @(posedge aclk) begin
        cnt_rvld_reg <= cnt_vld_reg[cnt_raddr];
        if (cmd.count_inc) inc_addr_reg <= bin_sel;
        if (!aresetn) begin
            inc_pend_reg <= 1'b0;
            peak_d_reg   <= 1'b0;
        end else begin
            inc_pend_reg <= cmd.count_inc;
            peak_d_reg   <= cmd.peak_step;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || cmd.clear) begin
            min_reg     <= SMAX;
            max_reg     <= SMIN;
            held_reg    <= '0;
            drop_reg    <= 1'b0;
            peak_reg    <= '0;
            cnt_vld_reg <= '0;
        end else begin
            if (cmd.load) begin
                if (held_reg < CNW'(nrh_pkg::MAX_SAMPLES)) begin
                    held_reg <= held_reg + 1'b1;
                    if (s_sample < min_reg) min_reg <= s_sample;
                    if (s_sample > max_reg) max_reg <= s_sample;
                end else begin
                    drop_reg <= 1'b1;
                end
            end
            if (inc_pend_reg) cnt_vld_reg[inc_addr_reg] <= 1'b1;
            if (peak_d_reg && cnt_rdata > peak_reg)
                peak_reg <= cnt_rdata;
        end
        if (!aresetn) cfg_reg <= nrh_pkg::CFG_W'(nrh_pkg::CFG_RESET);
        else if (cfg_wen) cfg_reg <= cfg_wdata;
    end

    // output register
    logic        v_reg;
    logic [63:0] d_reg;
    logic        l_reg;
    logic [nrh_pkg::NORM_W-1:0] norm;
    assign norm     = (peak_reg == '0) ? '0 : quo[nrh_pkg::NORM_W-1:0];
    assign out_free = !v_reg || m_tready;
    always_ff @(posedge aclk) begin
        if (out_load) begin
            d_reg <= {8'd0, drop_reg, max_reg, min_reg, norm, bin_idx};
            l_reg <= ({1'b0, bin_idx} == nb - 1'b1);
        end
        if (!aresetn) v_reg <= 1'b0;
        else if (out_load) v_reg <= 1'b1;
        else if (m_tready) v_reg <= 1'b0;
    end
    assign m_tvalid = v_reg;
    assign m_tdata  = d_reg;
    assign m_tlast  = l_reg;

    assert property (@(posedge aclk) disable iff (!aresetn)
        held_reg <= CNW'(nrh_pkg::MAX_SAMPLES))
        else $error("held count overrun");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (held_reg != '0) |-> min_reg <= max_reg)
        else $error("range inverted");
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.count_inc |-> !cmd.load)
        else $error("count during load");
endmodule

// File: sv/normalized_range_histogram_core.sv
// ----------------------------------------------------------------------------
// normalized_range_histogram_core
// Min/max scaled histogram over a run of signed samples.
// ----------------------------------------------------------------------------
// Input beats (s_*) carry one 16-bit sample each; s_tlast closes the run.
// Samples are taken one per cycle into a 4096-entry buffer while the range
// is tracked; samples beyond capacity are dropped and flagged.
// After the last beat s_tready stays low while every stored sample is read
// and divided by the range in the one-bit-per-cycle shared divider; on a
// flat range the division is skipped and every sample goes to bin 0.
// A peak search steps through the bins one per cycle, then each bin is
// normalized by the same divider and emitted.
// The m_* channel then gives one beat per bin, m_tlast on the final bin.
// A single output register holds a result while the receiver stalls; the
// block waits, losing nothing. Run state clears as the last bin beat is loaded.
// cfg_wen/cfg_wdata set bins_in_use (reset 64); write only while idle.
// Reset is synchronous, active low, and needs no clearing pass.
module normalized_range_histogram_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wen,
    input  logic [6:0]  cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [15:0] sample
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // [5:0] bin_index, [22:6] normalized_count,
                                   // [38:23] range_min, [54:39] range_max,
                                   // [55] overflowed
    output logic        m_tlast
);
    nrh_pkg::nrh_cmd_t cmd;
    nrh_pkg::nrh_sts_t sts;
    logic [nrh_pkg::HELD_W-1:0] held;
    logic [nrh_pkg::BIN_W:0]    nb;
    logic                       zero_span;
    logic [nrh_pkg::ADDR_W-1:0] rd_idx;
    logic [nrh_pkg::BIN_W-1:0]  bin_idx;
    logic                       out_load, out_free;
    nrh_pkg::nrh_cmd_t          cmd_x;

    always_comb begin
        cmd_x = cmd;
    end

    nrh_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_last(s_tlast),
        .held(held), .nb(nb), .zero_span(zero_span), .sts(sts),
        .cmd(cmd), .rd_idx(rd_idx), .bin_idx(bin_idx),
        .out_load(out_load), .out_free(out_free)
    );

    nrh_dpath u_dpath (
        .aclk(aclk), .aresetn(aresetn),
        .s_sample(s_tdata), .cfg_wdata(cfg_wdata), .cfg_wen(cfg_wen),
        .cmd(cmd_x), .rd_idx(rd_idx), .bin_idx(bin_idx),
        .out_load(out_load), .m_tready(m_tready),
        .m_tvalid(m_tvalid), .m_tdata(m_tdata), .m_tlast(m_tlast),
        .out_free(out_free), .held(held), .nb(nb), .zero_span(zero_span),
        .sts(sts)
    );
endmodule

// File: sim/normalized_range_histogram_core_test.sv
// ----------------------------------------------------------------------------
// normalized_range_histogram_core_test
// Self-checking testbench for the min/max scaled histogram core.
// ----------------------------------------------------------------------------
// Sample runs are streamed in; a local model buffers them, bins them by range
// and predicts one normalized count beat per bin. Output beats are compared
// field by field in order. Runs use several bin settings and idle patterns.
// ----------------------------------------------------------------------------
module normalized_range_histogram_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [5:0]  bin_index;
        logic [16:0] norm_count;
        logic [15:0] range_min;
        logic [15:0] range_max;
        logic        overflowed;
        logic        last_bin;
    } bin_beat_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_wen = 1'b0;
    logic [6:0]  cfg_wdata = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata = '0;
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [63:0] m_tdata;
    logic        m_tlast;

    normalized_range_histogram_core dut (
        .aclk(aclk), .aresetn(aresetn), .cfg_wen(cfg_wen), .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .s_tlast(s_tlast), .m_tvalid(m_tvalid), .m_tready(m_tready),
        .m_tdata(m_tdata), .m_tlast(m_tlast)
    );

    always #4 aclk = ~aclk;

    bin_beat_t           expected_bins[$];
    logic signed [15:0]  run_samples[$];
    logic signed [15:0]  run_lo, run_hi;
    logic                run_dropped;
    logic [6:0]          bins_reg;
    int                  fail_count = 0;
    int                  beats_seen = 0;
    int                  runs_sent = 0;
    int                  send_idle_pct = 0;
    int                  recv_stall_pct = 0;

    task automatic clear_run_model();
        run_samples.delete();
        run_lo = 16'sh7fff;
        run_hi = -16'sh8000;
        run_dropped = 1'b0;
    endtask

    task automatic predict_sample(logic signed [15:0] v, logic is_last);
        int nb;
        int peak;
        int counts[nrh_pkg::MAX_BINS];
        longint span, d, bin;
        bin_beat_t e;
        if (run_samples.size() < nrh_pkg::MAX_SAMPLES) begin
            run_samples.push_back(v);
            if (v < run_lo) run_lo = v;
            if (v > run_hi) run_hi = v;
        end else begin
            run_dropped = 1'b1;
        end
        if (!is_last) return;
        nb = bins_reg;
        if (nb < 2) nb = 2;
        if (nb > nrh_pkg::MAX_BINS) nb = nrh_pkg::MAX_BINS;
        foreach (counts[i]) counts[i] = 0;
        span = (run_hi > run_lo) ? longint'(run_hi) - longint'(run_lo) : 0;
        foreach (run_samples[i]) begin
            bin = 0;
            if (span != 0) begin
                d = longint'(run_samples[i]) - longint'(run_lo);
                if (d < 0) d = 0;
                bin = (longint'(nb - 1) * d) / span;
                if (bin > nb - 1) bin = nb - 1;
            end
            counts[bin]++;
        end
        peak = 0;
        for (int b = 0; b < nb; b++) if (counts[b] > peak) peak = counts[b];
        for (int b = 0; b < nb; b++) begin
            e.bin_index  = b[5:0];
            e.norm_count = (peak != 0) ? 17'((longint'(counts[b]) << 16) / peak) : '0;
            e.range_min  = run_lo;
            e.range_max  = run_hi;
            e.overflowed = run_dropped;
            e.last_bin   = (b == nb - 1);
            expected_bins.push_back(e);
        end
        clear_run_model();
    endtask

    task automatic report_mismatch(string what, longint got, longint want);
        $display("MISMATCH %s: got %0d expected %0d", what, got, want);
        fail_count++;
    endtask

    always @(posedge aclk) begin
        bin_beat_t e;
        if (aresetn && m_tvalid && m_tready) begin
            beats_seen++;
            if (expected_bins.size() == 0) begin
                report_mismatch("unexpected beat", m_tdata[5:0], -1);
            end else begin
                e = expected_bins.pop_front();
                if (m_tdata[5:0] != e.bin_index)
                    report_mismatch("bin_index", m_tdata[5:0], e.bin_index);
                if (m_tdata[22:6] != e.norm_count)
                    report_mismatch("normalized_count", m_tdata[22:6], e.norm_count);
                if (m_tdata[38:23] != e.range_min)
                    report_mismatch("range_min", $signed(m_tdata[38:23]),
                                    $signed(e.range_min));
                if (m_tdata[54:39] != e.range_max)
                    report_mismatch("range_max", $signed(m_tdata[54:39]),
                                    $signed(e.range_max));
                if (m_tdata[55] != e.overflowed)
                    report_mismatch("overflowed", m_tdata[55], e.overflowed);
                if (m_tlast != e.last_bin)
                    report_mismatch("last_bin", m_tlast, e.last_bin);
            end
        end
    end

    always @(posedge aclk)
        m_tready <= ($urandom_range(99) >= recv_stall_pct);

    task automatic send_sample(logic [15:0] v, logic is_last);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= v;
        s_tlast  <= is_last;
        do @(posedge aclk); while (!s_tready);
        predict_sample(v, is_last);
        if (is_last) runs_sent++;
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (expected_bins.size() != 0) @(posedge aclk);
        repeat (50) @(posedge aclk);
    endtask

    task automatic write_bins(logic [6:0] nb);
        drain_results();
        cfg_wen   <= 1'b1;
        cfg_wdata <= nb;
        @(posedge aclk);
        cfg_wen   <= 1'b0;
        bins_reg = nb;
    endtask

    function automatic logic [15:0] rand_sample(int mode);
        case (mode)
            0: return 16'($urandom);
            1: return 16'($urandom_range(20)) - 16'd10;
            default: return $urandom_range(1) ? 16'h7fff : 16'h8000;
        endcase
    endfunction

    task automatic send_random_run(int len);
        int mode;
        mode = $urandom_range(3);
        for (int i = 0; i < len; i++) send_sample(rand_sample(mode), i == len - 1);
    endtask

    task automatic test_directed();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        send_sample(16'h7fff, 1'b1);
        send_sample(16'h8000, 1'b0);
        send_sample(16'h7fff, 1'b0);
        send_sample(16'h0000, 1'b0);
        send_sample(16'hffff, 1'b1);
        send_sample(16'h0005, 1'b0);
        send_sample(16'h0005, 1'b1);
        send_sample(16'h5555, 1'b0);
        send_sample(16'haaaa, 1'b1);
        write_bins(7'd0);
        send_sample(16'h0001, 1'b0);
        send_sample(16'h0003, 1'b1);
        write_bins(7'd127);
        send_sample(16'h1234, 1'b0);
        send_sample(16'h8000, 1'b1);
        write_bins(7'd2);
        send_sample(16'h8000, 1'b0);
        send_sample(16'h0000, 1'b0);
        send_sample(16'h7fff, 1'b1);
    endtask

    task automatic test_random(int pct_send, int pct_recv, logic [6:0] nb, int runs);
        write_bins(nb);
        send_idle_pct = pct_send;
        recv_stall_pct = pct_recv;
        for (int r = 0; r < runs; r++) begin
            send_random_run($urandom_range(12, 1));
            if (r == runs / 2) drain_results();
        end
    endtask

    initial begin
        clear_run_model();
        bins_reg = 7'(nrh_pkg::CFG_RESET);
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_random(0, 0, 7'd64, 14);
        test_random(69, 0, 7'd3, 14);
        test_random(0, 69, 7'd17, 14);
        test_random(31, 31, 7'(1 + $urandom_range(63)), 14);
        test_random(31, 31, 7'd64, 10);
        drain_results();
        $display("Covered %0d runs and %0d bin beats, bin settings 0 through 127.",
                 runs_sent, beats_seen);
        $display("Included flat ranges, clamped bin settings and full-scale samples.");
        if (fail_count == 0 && expected_bins.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    initial begin
        #60ms;
        $display("Simulation FAILED");
        $finish;
    end
endmodule

// File: sim.f
sv/nrh_pkg.sv
sv/nrh_div.sv
sv/nrh_ctrl.sv
sv/nrh_dpath.sv
sv/normalized_range_histogram_core.sv
sim/normalized_range_histogram_core_test.sv
